### sv/tsamp_pkg.sv
// Shared types, constants and the bounds helper for the texture sampler.
package tsamp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 12;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = XW + YW;
    localparam int SIZE_W     = 9;
    localparam int BASE_W     = 14;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int COLOR_W    = 32;

    localparam logic [1:0] BM_CLAMP = 2'd0;
    localparam logic [1:0] BM_WRAP  = 2'd1;

    localparam logic [1:0] REG_TEX_WIDTH   = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_BOUNDS_MODE = 2'd2;
    localparam logic [1:0] REG_FILTER_MODE = 2'd3;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_BASE, F_MOD, F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE, B_WRITE, B_READ, B_W1, B_W2, B_MUL1, B_MUL2, B_SAT, B_OUT
    } t_bstate;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [1:0]        bmode;
        logic              bilin;
    } t_cfg;

    typedef struct packed {
        t_cmd                           cmd;
        logic                           bilin;
        logic [3:0][ADDR_W-1:0]         addr;
        logic [3:0]                     ok;
        logic signed [FRAC_W-1:0]       fx;
        logic signed [FRAC_W-1:0]       fy;
        logic [COLOR_W-1:0]             color;
    } t_job;

    typedef struct packed {
        logic            ok;
        logic [XW-1:0]   c;
    } t_bnd;

    // Bounds policy for one coordinate; m is the wrapped value in wrap mode.
    function automatic t_bnd bound_coord(input logic signed [BASE_W-1:0] v,
                                         input logic [SIZE_W-1:0] size,
                                         input logic [1:0] mode,
                                         input logic [XW-1:0] m);
        t_bnd r;
        logic signed [BASE_W-1:0] s;
        s    = BASE_W'($signed({1'b0, size}));
        r.ok = 1'b1;
        r.c  = v[XW-1:0];
        if (mode == BM_CLAMP) begin
            if (v >= s)
                r.c = XW'(size - 9'd1);
            else if (v < 0)
                r.c = '0;
        end else if (mode == BM_WRAP) begin
            r.c = m;
        end else begin
            r.ok = (v >= 0) && (v < s);
        end
        return r;
    endfunction

endpackage

### sv/texture_sampler_clamp_wrap_bilinear_top.sv
// Top level of the RGBA8 texture sampler with clamp, wrap and strict bounds.
// Usage:
//   Slave stream carries one command per item: tuser is the command (write,
//   read, sample, no-op); tdata packs coordinates, normalised sample coordinates
//   and the colour to write. Master stream returns one item per command: the
//   texel read, sampled or echoed in tdata and the strict-mode range flag in
//   tuser. The configuration channel sets width, height, bounds and filter
//   mode and is always ready; write it only while the block is idle.
//   Sequencing: the front end handles one item at a time, adding a bit-serial
//   modulo of both coordinates in wrap mode. The texel engine handles a write,
//   a read or nearest sample, and a bilinear sample, the last made longer by four
//   fetches from the single-port texel memory and the two multiply stages of the
//   blend. A two-entry queue lets the front end run ahead, so sustained
//   throughput is set by the slower of the two, depending on the modes.
//   Reset restores width and height 1, clamp, nearest, and empties both
//   sides; the texel memory is not cleared. When the receiver stalls the
//   result is held in the output register and the queue fills before the
//   slave channel stops taking items.
module texture_sampler_clamp_wrap_bilinear_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // coord_x[12:0] coord_y[25:13] norm_u[41:26] norm_v[57:42]
    // in_red[65:58] in_green[73:66] in_blue[81:74] in_alpha[89:82], zero above
    input  logic [95:0] i_s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red[7:0] out_green[15:8] out_blue[23:16] out_alpha[31:24]
    output logic [31:0] o_m_axis_tdata,
    // out_of_range[0]
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import tsamp_pkg::*;

    logic [SIZE_W-1:0] r_width, r_height;
    logic [1:0]        r_bmode;
    logic              r_filter;
    t_cfg              w_cfg;
    logic              w_push, w_full, w_pop, w_empty;
    t_job              w_fjob, w_qjob;
    logic              w_oor;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
        if (v == '0)
            return SIZE_W'(1);
        else if (int'(v) > maxv)
            return SIZE_W'(maxv);
        else
            return v;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(1);
            r_height <= SIZE_W'(1);
            r_bmode  <= BM_CLAMP;
            r_filter <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TEX_WIDTH:   r_width  <= i_cfg_data;
                REG_TEX_HEIGHT:  r_height <= i_cfg_data;
                REG_BOUNDS_MODE: r_bmode  <= i_cfg_data[1:0];
                REG_FILTER_MODE: r_filter <= i_cfg_data[0];
            endcase
        end
    end

    always_comb begin
        w_cfg.width  = eff_size(r_width, MAX_WIDTH);
        w_cfg.height = eff_size(r_height, MAX_HEIGHT);
        w_cfg.bmode  = r_bmode;
        w_cfg.bilin  = r_filter;
    end

    tsamp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_cmd     (t_cmd'(i_s_axis_tuser)),
        .i_coord_x ($signed(i_s_axis_tdata[12:0])),
        .i_coord_y ($signed(i_s_axis_tdata[25:13])),
        .i_norm_u  ($signed(i_s_axis_tdata[41:26])),
        .i_norm_v  ($signed(i_s_axis_tdata[57:42])),
        .i_color   (i_s_axis_tdata[89:58]),
        .i_cfg     (w_cfg),
        .o_push    (w_push),
        .o_job     (w_fjob),
        .i_full    (w_full)
    );

    tsamp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_empty (w_empty)
    );

    tsamp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_qjob),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_color (o_m_axis_tdata),
        .o_oor   (w_oor)
    );

    assign o_m_axis_tuser = w_oor;

endmodule

### sv/tsamp_mod.sv
// Bit-serial modulo of a signed coordinate by the texture size (true modulo).
module tsamp_mod (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tsamp_pkg::BASE_W-1:0] i_val,
    input  logic [tsamp_pkg::SIZE_W-1:0]        i_size,
    output logic                                o_busy,
    output logic [tsamp_pkg::XW-1:0]            o_res
);
    import tsamp_pkg::*;

    logic [3:0]          r_cnt;
    logic [BASE_W-1:0]   r_mag;
    logic [SIZE_W-1:0]   r_rem;
    logic [SIZE_W-1:0]   r_size;
    logic                r_neg;
    logic [SIZE_W:0]     w_try;
    logic [SIZE_W:0]     w_sub;

    always_comb begin
        w_try = {r_rem, r_mag[BASE_W-1]};
        w_sub = (w_try >= {1'b0, r_size}) ? w_try - {1'b0, r_size} : w_try;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 4'(BASE_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_val[BASE_W-1];
            r_mag  <= i_val[BASE_W-1] ? BASE_W'(-i_val) : BASE_W'(i_val);
            r_rem  <= '0;
            r_size <= i_size;
        end else if (r_cnt != '0) begin
            r_rem <= w_sub[SIZE_W-1:0];
            r_mag <= {r_mag[BASE_W-2:0], 1'b0};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_res  = (r_neg && r_rem != '0) ? XW'(r_size - r_rem) : r_rem[XW-1:0];

endmodule

### sv/tsamp_front.sv
// Front end: accepts items, scales sample coordinates and resolves texel addresses.
module tsamp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  tsamp_pkg::t_cmd                     i_cmd,
    input  logic signed [12:0]                  i_coord_x,
    input  logic signed [12:0]                  i_coord_y,
    input  logic signed [15:0]                  i_norm_u,
    input  logic signed [15:0]                  i_norm_v,
    input  logic [tsamp_pkg::COLOR_W-1:0]       i_color,
    input  tsamp_pkg::t_cfg                     i_cfg,
    output logic                                o_push,
    output tsamp_pkg::t_job                     o_job,
    input  logic                                i_full
);
    import tsamp_pkg::*;

    localparam int PW = 16 + SIZE_W + 1;

    t_fstate r_state, n_state;
    t_cmd                      r_cmd;
    logic signed [12:0]        r_cx, r_cy;
    logic signed [15:0]        r_nu, r_nv;
    logic [COLOR_W-1:0]        r_color;
    logic signed [PW-1:0]      r_pu, r_pv;
    logic signed [BASE_W-1:0]  r_bx, r_by;
    logic signed [FRAC_W-1:0]  r_fx, r_fy;

    logic signed [BASE_W-1:0]  n_bx, n_by;
    logic signed [FRAC_W-1:0]  n_fx, n_fy;
    logic                      w_mod_start;
    logic                      w_busy_x, w_busy_y;
    logic [XW-1:0]             w_mx, w_my, w_mx1, w_my1;
    t_bnd                      w_x0, w_x1, w_y0, w_y1;

    // Truncate toward zero, keep the signed remainder as the fraction.
    function automatic logic [BASE_W+FRAC_W-1:0] split(input logic signed [PW-1:0] p);
        logic [PW-1:0]             mag;
        logic [BASE_W-1:0]         qm;
        logic [FRAC_BITS-1:0]      fm;
        logic signed [BASE_W-1:0]  q;
        logic signed [FRAC_W-1:0]  f;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        qm  = BASE_W'(mag >> FRAC_BITS);
        fm  = mag[FRAC_BITS-1:0];
        q   = p[PW-1] ? BASE_W'(-$signed(qm)) : $signed(qm);
        f   = p[PW-1] ? FRAC_W'(-$signed({1'b0, fm})) : $signed({1'b0, fm});
        return {q, f};
    endfunction

    always_comb begin
        if (r_cmd == CMD_SAMPLE) begin
            {n_bx, n_fx} = split(r_pu);
            {n_by, n_fy} = split(r_pv);
        end else begin
            n_bx = BASE_W'(r_cx);
            n_by = BASE_W'(r_cy);
            n_fx = '0;
            n_fy = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        o_push      = 1'b0;
        w_mod_start = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = F_MUL;
            end
            F_MUL: n_state = F_BASE;
            F_BASE: begin
                w_mod_start = (i_cfg.bmode == BM_WRAP);
                n_state     = w_mod_start ? F_MOD : F_PUSH;
            end
            F_MOD: begin
                if (!w_busy_x && !w_busy_y) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_cmd   <= i_cmd;
            r_cx    <= i_coord_x;
            r_cy    <= i_coord_y;
            r_nu    <= i_norm_u;
            r_nv    <= i_norm_v;
            r_color <= i_color;
        end
        if (r_state == F_MUL) begin
            r_pu <= PW'(r_nu) * $signed({1'b0, i_cfg.width});
            r_pv <= PW'(r_nv) * $signed({1'b0, i_cfg.height});
        end
        if (r_state == F_BASE) begin
            r_bx <= n_bx;
            r_by <= n_by;
            r_fx <= n_fx;
            r_fy <= n_fy;
        end
    end

    tsamp_mod u_mod_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_val   (n_bx),
        .i_size  (i_cfg.width),
        .o_busy  (w_busy_x),
        .o_res   (w_mx)
    );

    tsamp_mod u_mod_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_val   (n_by),
        .i_size  (i_cfg.height),
        .o_busy  (w_busy_y),
        .o_res   (w_my)
    );

    always_comb begin
        w_mx1 = ({1'b0, w_mx} + 9'd1 == i_cfg.width)  ? '0 : w_mx + 8'd1;
        w_my1 = ({1'b0, w_my} + 9'd1 == i_cfg.height) ? '0 : w_my + 8'd1;
        w_x0  = bound_coord(r_bx, i_cfg.width, i_cfg.bmode, w_mx);
        w_x1  = bound_coord(r_bx + 14'sd1, i_cfg.width, i_cfg.bmode, w_mx1);
        w_y0  = bound_coord(r_by, i_cfg.height, i_cfg.bmode, w_my);
        w_y1  = bound_coord(r_by + 14'sd1, i_cfg.height, i_cfg.bmode, w_my1);
        o_job.cmd     = r_cmd;
        o_job.bilin   = i_cfg.bilin;
        o_job.addr[0] = {w_y0.c, w_x0.c};
        o_job.addr[1] = {w_y0.c, w_x1.c};
        o_job.addr[2] = {w_y1.c, w_x0.c};
        o_job.addr[3] = {w_y1.c, w_x1.c};
        o_job.ok[0]   = w_x0.ok && w_y0.ok;
        o_job.ok[1]   = w_x1.ok && w_y0.ok;
        o_job.ok[2]   = w_x0.ok && w_y1.ok;
        o_job.ok[3]   = w_x1.ok && w_y1.ok;
        o_job.fx      = r_fx;
        o_job.fy      = r_fy;
        o_job.color   = r_color;
    end

endmodule

### sv/tsamp_queue.sv
// Two-entry job queue between the front end and the texel engine.
module tsamp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tsamp_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output tsamp_pkg::t_job o_job,
    output logic            o_empty
);
    import tsamp_pkg::*;

    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_job;
    end

    assign o_job   = r_q[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

### sv/tsamp_back.sv
// Texel engine: texel memory, fetch sequencing, bilinear blend and result register.
module tsamp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  tsamp_pkg::t_job               i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tsamp_pkg::COLOR_W-1:0] o_color,
    output logic                          o_oor
);
    import tsamp_pkg::*;

    localparam int C1_W = 24;
    localparam int C_W  = 40;

    t_bstate r_state, n_state;
    t_job               r_job;
    logic [1:0]         r_idx, r_last;
    logic               r_rd_vld;
    logic [1:0]         r_rd_tag;
    logic [COLOR_W-1:0] r_rdata;
    logic [COLOR_W-1:0] r_tex [4];
    logic signed [C1_W-1:0] r_c1 [4];
    logic signed [C1_W-1:0] r_c2 [4];
    logic signed [C_W-1:0]  r_c  [4];
    logic [COLOR_W-1:0] r_res;
    logic               r_res_oor;
    logic               r_ovalid;
    logic [COLOR_W-1:0] r_ocolor;
    logic               r_ooor;
    logic [COLOR_W-1:0] r_mem [MAX_WIDTH*MAX_HEIGHT];

    logic               w_we, w_re, w_load;
    logic [ADDR_W-1:0]  w_raddr;
    logic signed [C1_W-1:0] w_wx0, w_wy0, w_fx, w_fy;
    logic [COLOR_W-1:0] w_sat;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_job.cmd)
                        CMD_WRITE:  n_state = B_WRITE;
                        CMD_READ:   n_state = B_READ;
                        CMD_SAMPLE: n_state = B_READ;
                        CMD_NOP:    n_state = B_OUT;
                    endcase
                end
            end
            B_WRITE: begin
                w_we    = r_job.ok[0];
                n_state = B_OUT;
            end
            B_READ: begin
                w_re = 1'b1;
                if (r_idx == r_last) n_state = B_W1;
            end
            B_W1: n_state = B_W2;
            B_W2: n_state = (r_job.cmd == CMD_SAMPLE && r_job.bilin) ? B_MUL1 : B_OUT;
            B_MUL1: n_state = B_MUL2;
            B_MUL2: n_state = B_SAT;
            B_SAT:  n_state = B_OUT;
            B_OUT: begin
                if (!r_ovalid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign w_raddr = r_job.addr[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_re;
            if (w_load)       r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_job.addr[0]] <= r_job.color;
        if (w_re) r_rdata <= r_mem[w_raddr];
    end

    // Blend weights: (1 - f) and f; f takes the fraction's sign, so it may be negative.
    always_comb begin
        w_fx  = C1_W'(r_job.fx);
        w_fy  = C1_W'(r_job.fy);
        w_wx0 = C1_W'(1 << FRAC_BITS) - w_fx;
        w_wy0 = C1_W'(1 << FRAC_BITS) - w_fy;
        for (int k = 0; k < 4; k++) begin
            if (r_c[k] <= 0)
                w_sat[8*k +: 8] = 8'd0;
            else if ((r_c[k] >>> (2*FRAC_BITS)) > 255)
                w_sat[8*k +: 8] = 8'hFF;
            else
                w_sat[8*k +: 8] = r_c[k][2*FRAC_BITS +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_idx  <= '0;
            r_last <= (i_job.cmd == CMD_SAMPLE && i_job.bilin) ? 2'd3 : 2'd0;
            if (i_job.cmd == CMD_NOP) begin
                r_res     <= '0;
                r_res_oor <= 1'b0;
            end
        end
        if (w_re) r_idx <= r_idx + 2'd1;
        if (r_rd_vld) r_tex[r_rd_tag] <= r_job.ok[r_rd_tag] ? r_rdata : '0;
        r_rd_tag <= r_idx;
        if (r_state == B_WRITE) begin
            r_res     <= r_job.color;
            r_res_oor <= !r_job.ok[0];
        end
        if (r_state == B_W2) begin
            r_res     <= r_tex[0];
            r_res_oor <= !r_job.ok[0];
        end
        if (r_state == B_MUL1) begin
            for (int k = 0; k < 4; k++) begin
                r_c1[k] <= $signed({16'd0, r_tex[0][8*k +: 8]}) * w_wx0
                         + $signed({16'd0, r_tex[1][8*k +: 8]}) * w_fx;
                r_c2[k] <= $signed({16'd0, r_tex[2][8*k +: 8]}) * w_wx0
                         + $signed({16'd0, r_tex[3][8*k +: 8]}) * w_fx;
            end
        end
        if (r_state == B_MUL2) begin
            for (int k = 0; k < 4; k++)
                r_c[k] <= C_W'(r_c1[k]) * C_W'(w_wy0) + C_W'(r_c2[k]) * C_W'(w_fy);
        end
        if (r_state == B_SAT) begin
            r_res     <= w_sat;
            r_res_oor <= !(&r_job.ok);
        end
        if (w_load) begin
            r_ocolor <= r_res;
            r_ooor   <= r_res_oor;
        end
    end

    assign o_valid = r_ovalid;
    assign o_color = r_ocolor;
    assign o_oor   = r_ooor;

endmodule

### tb/tb_texture_sampler_clamp_wrap_bilinear_top.sv
// Self-checking testbench for the texture sampler: random commands checked against a texel model.
module tb_texture_sampler_clamp_wrap_bilinear_top;
    import tsamp_pkg::*;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [12:0] cx;
        logic signed [12:0] cy;
        logic signed [15:0] nu;
        logic signed [15:0] nv;
        logic [31:0]        color;
    } t_item;

    typedef struct {
        logic [31:0] color;
        logic        oor;
    } t_texel_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [95:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;
    logic [0:0]  m_user;
    logic        cfg_ready;

    texture_sampler_clamp_wrap_bilinear_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Texel model state
    logic [31:0] tex_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
    bit          filled  [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [8:0]  cur_w = 9'd1;
    logic [8:0]  cur_h = 9'd1;
    logic [1:0]  cur_bm = BM_CLAMP;
    logic        cur_fm = 1'b0;

    t_item      cmd_q[$];
    t_texel_res result_q[$];
    t_item      cur_item;
    int         errors = 0;
    int         accepted = 0;
    bit         quiet = 1'b0;
    int         src_gap = 0;
    int         sink_hold = 0;
    bit         long_done = 1'b0;

    function automatic longint eff_size(logic [8:0] c, longint maxv);
        if (c == 0) return 1;
        if (longint'(c) > maxv) return maxv;
        return longint'(c);
    endfunction

    function automatic bit bound_axis(inout longint v, input longint size);
        if (cur_bm == BM_CLAMP) begin
            if (v >= size) v = size - 1;
            else if (v < 0) v = 0;
        end else if (cur_bm == BM_WRAP) begin
            v = ((v % size) + size) % size;
        end else if (v < 0 || v >= size) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit texel_addr(input longint x, input longint y, output int a);
        bit okx, oky;
        okx = bound_axis(x, eff_size(cur_w, MAX_WIDTH));
        oky = bound_axis(y, eff_size(cur_h, MAX_HEIGHT));
        a = int'(y * MAX_WIDTH + x);
        return okx && oky;
    endfunction

    function automatic logic [31:0] fetch_texel(longint x, longint y, inout logic oor);
        int a;
        if (!texel_addr(x, y, a)) begin
            oor = 1'b1;
            return '0;
        end
        return tex_mem[a];
    endfunction

    function automatic void scale_axis(longint n, longint size, output longint b,
                                       output longint f);
        longint p;
        p = n * size;
        b = (p >= 0) ? (p >>> FRAC_BITS) : -((-p) >>> FRAC_BITS);
        f = p - b * (longint'(1) << FRAC_BITS);
    endfunction

    function automatic t_texel_res sample_texel(t_item it);
        t_texel_res r;
        int a;
        longint x1, y1, fx, fy, c1, c2, c, v, one;
        logic [31:0] t00, t10, t01, t11;
        r.color = '0;
        r.oor = 1'b0;
        one = longint'(1) << FRAC_BITS;
        case (it.cmd)
            CMD_WRITE: begin
                if (texel_addr(it.cx, it.cy, a)) tex_mem[a] = it.color;
                else r.oor = 1'b1;
                r.color = it.color;
            end
            CMD_READ: r.color = fetch_texel(it.cx, it.cy, r.oor);
            CMD_SAMPLE: begin
                scale_axis(it.nu, eff_size(cur_w, MAX_WIDTH), x1, fx);
                scale_axis(it.nv, eff_size(cur_h, MAX_HEIGHT), y1, fy);
                if (!cur_fm) begin
                    r.color = fetch_texel(x1, y1, r.oor);
                end else begin
                    t00 = fetch_texel(x1, y1, r.oor);
                    t10 = fetch_texel(x1 + 1, y1, r.oor);
                    t01 = fetch_texel(x1, y1 + 1, r.oor);
                    t11 = fetch_texel(x1 + 1, y1 + 1, r.oor);
                    for (int k = 0; k < 4; k++) begin
                        c1 = longint'(t00[8*k +: 8]) * (one - fx) + longint'(t10[8*k +: 8]) * fx;
                        c2 = longint'(t01[8*k +: 8]) * (one - fx) + longint'(t11[8*k +: 8]) * fx;
                        c = c1 * (one - fy) + c2 * fy;
                        v = (c <= 0) ? 0 : (c >>> (2 * FRAC_BITS));
                        if (v > 255) v = 255;
                        r.color[8*k +: 8] = v[7:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
        errors++;
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Source: present items from the command queue
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                result_q.push_back(sample_texel(cur_item));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (cmd_q.size() > 0 && (quiet || $urandom_range(0, 9) != 0)) begin
                    cur_item = cmd_q.pop_front();
                    s_valid <= 1'b1;
                    s_user <= cur_item.cmd;
                    s_data <= {6'b0, cur_item.color, cur_item.nv, cur_item.nu,
                               cur_item.cy, cur_item.cx};
                end else begin
                    s_valid <= 1'b0;
                    if (!quiet && cmd_q.size() > 0) src_gap <= $urandom_range(1, 17);
                end
            end
        end
    end

    // Sink: random back-pressure, one long hold-off, and checking
    always @(posedge i_clk) begin
        t_texel_res w;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report("unexpected item", '0, m_data);
                end else begin
                    w = result_q.pop_front();
                    if (m_data[7:0] !== w.color[7:0])
                        report("red", 32'(w.color[7:0]), 32'(m_data[7:0]));
                    if (m_data[15:8] !== w.color[15:8])
                        report("green", 32'(w.color[15:8]), 32'(m_data[15:8]));
                    if (m_data[23:16] !== w.color[23:16])
                        report("blue", 32'(w.color[23:16]), 32'(m_data[23:16]));
                    if (m_data[31:24] !== w.color[31:24])
                        report("alpha", 32'(w.color[31:24]), 32'(m_data[31:24]));
                    if (m_user[0] !== w.oor)
                        report("out_of_range", 32'(w.oor), 32'(m_user[0]));
                end
            end
            if (!long_done && accepted >= 300) begin
                long_done <= 1'b1;
                sink_hold <= 400;
                m_ready <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                sink_hold <= $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic drain();
        while (cmd_q.size() > 0 || s_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TEX_WIDTH:   cur_w = val;
            REG_TEX_HEIGHT:  cur_h = val;
            REG_BOUNDS_MODE: cur_bm = val[1:0];
            default:         cur_fm = val[0];
        endcase
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_cmd(logic [1:0] c, int x, int y, int u, int v, logic [31:0] col);
        t_item it;
        it.cmd = c;
        it.cx = 13'(x);
        it.cy = 13'(y);
        it.nu = 16'(u);
        it.nv = 16'(v);
        it.color = col;
        cmd_q.push_back(it);
    endtask

    task automatic run_phase(logic [8:0] w, logic [8:0] h, logic [1:0] bm, logic fm, int n);
        int ew, eh, c, x, y, u, v;
        logic [31:0] col;
        drain();
        cfg_write(REG_TEX_WIDTH, w);
        cfg_write(REG_TEX_HEIGHT, h);
        cfg_write(REG_BOUNDS_MODE, {7'b0, bm[1:0]});
        cfg_write(REG_FILTER_MODE, {8'b0, fm});
        ew = int'(eff_size(w, MAX_WIDTH));
        eh = int'(eff_size(h, MAX_HEIGHT));
        // fill the visible region so that no read hits an unwritten texel
        for (int yy = 0; yy < eh; yy++)
            for (int xx = 0; xx < ew; xx++)
                if (!filled[yy*MAX_WIDTH + xx]) begin
                    filled[yy*MAX_WIDTH + xx] = 1'b1;
                    push_cmd(CMD_WRITE, xx, yy, $urandom, $urandom, $urandom);
                end
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 15);
            c = (c == 15) ? CMD_NOP : c % 3;
            if ($urandom_range(0, 5) == 0) begin
                x = $urandom; y = $urandom; u = $urandom; v = $urandom;
            end else begin
                x = $urandom_range(0, ew + 5) - 3;
                y = $urandom_range(0, eh + 5) - 3;
                u = $urandom_range(0, 10240) - 5120;
                v = $urandom_range(0, 10240) - 5120;
            end
            col = $urandom;
            push_cmd(c[1:0], x, y, u, v, col);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_phase(9'd0, 9'd0, BM_CLAMP, 1'b0, 0);
        // corner coordinates, sample extremes and the idle command
        push_cmd(CMD_WRITE, -4096, 4095, 0, 0, 32'hFFFF_FFFF);
        push_cmd(CMD_READ, 4095, -4096, 0, 0, 32'h0);
        push_cmd(CMD_WRITE, 0, 0, 0, 0, 32'h00FF_00FF);
        push_cmd(CMD_SAMPLE, 0, 0, -32768, 32767, 32'h0);
        push_cmd(CMD_SAMPLE, 0, 0, 32767, -32768, 32'h0);
        push_cmd(CMD_SAMPLE, 0, 0, 0, 0, 32'h0);
        push_cmd(CMD_NOP, -1, -1, -1, -1, 32'hFFFF_FFFF);
        push_cmd(CMD_READ, 0, 0, 0, 0, 32'h0);
        run_phase(9'd4, 9'd3, BM_WRAP, 1'b1, 120);
        run_phase(9'd256, 9'd1, 2'd2, 1'b1, 100);
        run_phase(9'd1, 9'd40, BM_WRAP, 1'b0, 80);
        run_phase(9'd511, 9'd1, 2'd3, 1'b1, 80);
        run_phase(9'd7, 9'd9, 2'd2, 1'b0, 80);
        run_phase(9'd16, 9'd4, BM_WRAP, 1'b1, 100);
        run_phase(9'd5, 9'd9, BM_CLAMP, 1'b1, 80);
        drain();
        quiet = 1'b1;
        run_phase(9'd3, 9'd5, 2'd2, 1'b1, 80);
        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule
